// File: design/ship_drrip_replacement_macros.svh
// assertion helpers, sampled on clk and disabled while arst_n is low
`ifndef SHIP_DRRIP_REPLACEMENT_MACROS_SVH
`define SHIP_DRRIP_REPLACEMENT_MACROS_SVH

// same-cycle implication
`define SDR_ASSERT_IMPL(lbl, cond, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (prop)) \
		else $error("ship_drrip_replacement: check failed");

// next-cycle implication
`define SDR_ASSERT_NEXT(lbl, cond, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (prop)) \
		else $error("ship_drrip_replacement: check failed");

`endif

// File: design/shipdrrip_pkg.sv
package shipdrrip_pkg;

	localparam int unsigned DEF_NUM_SETS      = 2048;
	localparam int unsigned DEF_NUM_WAYS      = 16;
	localparam int unsigned DEF_SIG_BITS      = 6;
	localparam int unsigned DEF_LEADER_STRIDE = 64;

	localparam int unsigned SET_INDEX_W = 11;
	localparam int unsigned SIGNATURE_W = 6;
	localparam int unsigned WAY_FIELD_W = 4;
	localparam int unsigned RRPV_W      = 2;
	localparam int unsigned RC_W        = 2;
	localparam int unsigned PSEL_W      = 10;

	localparam logic [RRPV_W-1:0] RRPV_NEAR  = 2'd0;
	localparam logic [RRPV_W-1:0] RRPV_SRRIP = 2'd2;
	localparam logic [RRPV_W-1:0] RRPV_MAX   = 2'd3;

	localparam logic [RC_W-1:0] RC_RESET  = 2'd1;
	localparam logic [RC_W-1:0] RC_STRONG = 2'd2;
	localparam logic [RC_W-1:0] RC_MAX    = 2'd3;

	localparam logic [PSEL_W-1:0] PSEL_RESET = 10'd512;
	localparam logic [PSEL_W-1:0] PSEL_MAX   = 10'd1023;

	typedef struct packed {
		logic [SET_INDEX_W-1:0] set_index;
		logic [SIGNATURE_W-1:0] signature;
		logic                   is_hit;
		logic [WAY_FIELD_W-1:0] hit_way;
		logic                   bimodal_pick;
	} req_word_t;

	typedef struct packed {
		logic [WAY_FIELD_W-1:0] chosen_way;
		logic [RRPV_W-1:0]      new_rrpv;
	} rsp_word_t;

endpackage

// File: design/ship_drrip_replacement.sv
// Replacement engine for a set-associative cache (signature-based reuse prediction with dueling
// SRRIP/BRRIP insertion). Each request word is one access; each yields one response word with
// the way written and its new RRPV. Per-set RRPVs and line signatures sit in two set-wide
// memories and the signature reuse counters in a third, all with registered reads. After reset
// the block runs a clearing pass over every set and every reuse counter before it takes its
// first request. Requests are taken one at a time: SETQ and SETR reduce the set index and hit
// way by constant multiplication, READ reads the set, LOOK modifies and writes it back, a miss
// then passes through DEC to lower the evicted line's reuse counter, which can only be
// addressed once the set's signatures have been read, and EMIT waits until the previous
// response word has been taken.
`include "ship_drrip_replacement_macros.svh"

module ship_drrip_replacement
	import shipdrrip_pkg::*;
#(
	parameter int unsigned NUM_SETS      = DEF_NUM_SETS,
	parameter int unsigned NUM_WAYS      = DEF_NUM_WAYS,
	parameter int unsigned SIG_BITS      = DEF_SIG_BITS,
	parameter int unsigned LEADER_STRIDE = DEF_LEADER_STRIDE
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	output logic      req_stall,
	input  req_word_t req_word,
	output logic      rsp_valid,
	input  logic      rsp_stall,
	output rsp_word_t rsp_word
);

	localparam int unsigned SET_W       = $clog2(NUM_SETS);
	localparam int unsigned WAY_W       = $clog2(NUM_WAYS);
	localparam int unsigned SIG_ENTRIES = 2 ** SIG_BITS;
	localparam int unsigned RRPV_WORD_W = RRPV_W * NUM_WAYS;
	localparam int unsigned SIG_WORD_W  = SIG_BITS * NUM_WAYS;
	localparam int unsigned CLR_COUNT   = (NUM_SETS > SIG_ENTRIES) ? NUM_SETS : SIG_ENTRIES;
	localparam int unsigned CLR_W       = $clog2(CLR_COUNT);

	localparam int unsigned SH_SET  = SET_INDEX_W + $clog2(NUM_SETS);
	localparam longint unsigned M_SET = ((64'd1 << SH_SET) + NUM_SETS - 1) / NUM_SETS;
	localparam int unsigned SETP_W  = 2 * SET_INDEX_W + 2;

	localparam int unsigned SH_POS  = SET_W + $clog2(LEADER_STRIDE);
	localparam longint unsigned M_POS = ((64'd1 << SH_POS) + LEADER_STRIDE - 1) / LEADER_STRIDE;
	localparam int unsigned POSP_W  = 2 * SET_W + 2;

	localparam int unsigned SH_WAY  = WAY_FIELD_W + WAY_W;
	localparam longint unsigned M_WAY = ((64'd1 << SH_WAY) + NUM_WAYS - 1) / NUM_WAYS;
	localparam int unsigned WAYP_W  = 2 * WAY_FIELD_W + 2;

	typedef enum logic [7:0] {
		ST_CLEAR = 8'b0000_0001,
		ST_IDLE  = 8'b0000_0010,
		ST_SETQ  = 8'b0000_0100,
		ST_SETR  = 8'b0000_1000,
		ST_READ  = 8'b0001_0000,
		ST_LOOK  = 8'b0010_0000,
		ST_DEC   = 8'b0100_0000,
		ST_EMIT  = 8'b1000_0000
	} state_t;

	state_t state_q, state_d;
	logic [CLR_W-1:0] clr_q;
	logic             clr_last;
	logic             clr_sets;
	logic             clr_sigs;

	logic             req_accept;
	logic             rsp_free;
	logic             rsp_valid_q;
	rsp_word_t        rsp_word_q;
	rsp_word_t        res_q;

	logic [SET_INDEX_W-1:0] x_q;
	logic [SIG_BITS-1:0]    sig_q;
	logic                   hit_q;
	logic [WAY_FIELD_W-1:0] hw_raw_q;
	logic                   bim_q;
	logic [SET_INDEX_W-1:0] sq_q;
	logic [WAY_FIELD_W-1:0] hwq_q;
	logic [SET_W-1:0]       set_q;
	logic [WAY_W-1:0]       hway_q;
	logic [SET_W-1:0]       pq_q;
	logic [SIG_BITS-1:0]    old_sig_q;
	logic [PSEL_W-1:0]      psel_q;

	logic [SETP_W-1:0]      set_prod;
	logic [WAYP_W-1:0]      way_prod;
	logic [POSP_W-1:0]      pos_prod;
	logic [SET_INDEX_W-1:0] set_rem;
	logic [WAY_FIELD_W-1:0] way_rem;
	logic [SET_W-1:0]       pos_base;
	logic                   srrip_leader;
	logic                   brrip_leader;

	logic [RRPV_WORD_W-1:0] rrpv_mem [NUM_SETS];
	logic [SIG_WORD_W-1:0]  sig_mem [NUM_SETS];
	logic [RC_W-1:0]        rc_mem [SIG_ENTRIES];
	logic [RRPV_WORD_W-1:0] rrpv_rd_q;
	logic [SIG_WORD_W-1:0]  sig_rd_q;
	logic [RC_W-1:0]        rc_rd_q;

	logic                   set_re;
	logic                   rrpv_we;
	logic [SET_W-1:0]       set_waddr;
	logic [RRPV_WORD_W-1:0] rrpv_wdata;
	logic                   sig_we;
	logic [SIG_WORD_W-1:0]  sig_wdata;
	logic                   rc_re;
	logic [SIG_BITS-1:0]    rc_raddr;
	logic                   rc_we;
	logic [SIG_BITS-1:0]    rc_waddr;
	logic [RC_W-1:0]        rc_wdata;

	logic [RRPV_W-1:0]      rr_way [NUM_WAYS];
	logic [NUM_WAYS-1:0]    any_lvl [RRPV_MAX+1];
	logic [RRPV_W-1:0]      top;
	logic [RRPV_W-1:0]      lift;
	logic [NUM_WAYS-1:0]    match;
	logic [NUM_WAYS-1:0]    first;
	logic [WAY_W-1:0]       victim;
	logic [RRPV_W-1:0]      brrip_depth;
	logic [RRPV_W-1:0]      depth;
	logic [SIG_BITS-1:0]    old_sig;
	logic [RRPV_WORD_W-1:0] rrpv_new;
	logic [SIG_WORD_W-1:0]  sig_new;
	logic [PSEL_W-1:0]      psel_d;

	assign req_stall  = (state_q != ST_IDLE);
	assign req_accept = req_valid && !req_stall;
	assign rsp_free   = !rsp_valid_q || !rsp_stall;
	assign rsp_valid  = rsp_valid_q;
	assign rsp_word   = rsp_word_q;

	assign clr_last = (32'(clr_q) == CLR_COUNT - 1);
	assign clr_sets = (state_q == ST_CLEAR) && (32'(clr_q) < NUM_SETS);
	assign clr_sigs = (state_q == ST_CLEAR) && (32'(clr_q) < SIG_ENTRIES);

	// reductions by constant multiplication with exact reciprocals
	assign set_prod = SETP_W'(x_q) * SETP_W'(M_SET);
	assign way_prod = WAYP_W'(hw_raw_q) * WAYP_W'(M_WAY);
	assign pos_prod = POSP_W'(set_q) * POSP_W'(M_POS);
	assign set_rem  = x_q - SET_INDEX_W'(64'(sq_q) * 64'(NUM_SETS));
	assign way_rem  = hw_raw_q - WAY_FIELD_W'(32'(hwq_q) * 32'(NUM_WAYS));
	assign pos_base = SET_W'(64'(pq_q) * 64'(LEADER_STRIDE));
	assign srrip_leader = (set_q == pos_base);
	assign brrip_leader = ({1'b0, set_q} == ({1'b0, pos_base} + 1'b1));

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR: if (clr_last) state_d = ST_IDLE;
			ST_IDLE:  if (req_accept) state_d = ST_SETQ;
			ST_SETQ:  state_d = ST_SETR;
			ST_SETR:  state_d = ST_READ;
			ST_READ:  state_d = ST_LOOK;
			ST_LOOK:  state_d = hit_q ? ST_EMIT : ST_DEC;
			ST_DEC:   state_d = ST_EMIT;
			ST_EMIT:  if (rsp_free) state_d = ST_IDLE;
			default:  state_d = ST_CLEAR;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			psel_q      <= PSEL_RESET;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR) begin
				clr_q <= clr_q + 1'b1;
			end
			psel_q <= psel_d;
			if (state_q == ST_EMIT && rsp_free) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req_accept) begin
			x_q      <= req_word.set_index;
			sig_q    <= SIG_BITS'(req_word.signature);
			hit_q    <= req_word.is_hit;
			hw_raw_q <= req_word.hit_way;
			bim_q    <= req_word.bimodal_pick;
		end
		if (state_q == ST_SETQ) begin
			sq_q  <= SET_INDEX_W'(set_prod >> SH_SET);
			hwq_q <= WAY_FIELD_W'(way_prod >> SH_WAY);
		end
		if (state_q == ST_SETR) begin
			set_q  <= SET_W'(set_rem);
			hway_q <= WAY_W'(way_rem);
		end
		if (state_q == ST_READ) begin
			pq_q <= SET_W'(pos_prod >> SH_POS);
		end
		if (state_q == ST_LOOK) begin
			old_sig_q <= old_sig;
			res_q.chosen_way <= hit_q ? WAY_FIELD_W'(hway_q) : WAY_FIELD_W'(victim);
			res_q.new_rrpv   <= hit_q ? RRPV_NEAR : depth;
		end
		if (state_q == ST_EMIT && rsp_free) begin
			rsp_word_q <= res_q;
		end
	end

	// victim search, aging, hit promotion, insertion depth and PSEL update
	always_comb begin
		for (int w = 0; w < NUM_WAYS; w++) begin
			rr_way[w] = rrpv_rd_q[w*RRPV_W +: RRPV_W];
		end
		for (int l = 0; l <= RRPV_MAX; l++) begin
			for (int w = 0; w < NUM_WAYS; w++) begin
				any_lvl[l][w] = (rr_way[w] == RRPV_W'(l));
			end
		end
		priority if (|any_lvl[3]) top = 2'd3;
		else if (|any_lvl[2])     top = 2'd2;
		else if (|any_lvl[1])     top = 2'd1;
		else                      top = 2'd0;
		lift  = RRPV_MAX - top;
		match = '0;
		for (int w = 0; w < NUM_WAYS; w++) begin
			match[w] = (rr_way[w] == top);
		end
		first  = match & (~match + 1'b1);
		victim = '0;
		for (int w = 0; w < NUM_WAYS; w++) begin
			victim = victim | (first[w] ? WAY_W'(w) : '0);
		end

		brrip_depth = bim_q ? RRPV_SRRIP : RRPV_MAX;
		priority if (rc_rd_q >= RC_STRONG) depth = RRPV_NEAR;
		else if (srrip_leader)            depth = RRPV_SRRIP;
		else if (brrip_leader)            depth = brrip_depth;
		else if (psel_q >= PSEL_RESET)    depth = RRPV_SRRIP;
		else                              depth = brrip_depth;

		old_sig = sig_rd_q[victim*SIG_BITS +: SIG_BITS];

		if (hit_q) begin
			rrpv_new = rrpv_rd_q;
			rrpv_new[hway_q*RRPV_W +: RRPV_W] = RRPV_NEAR;
		end else begin
			for (int w = 0; w < NUM_WAYS; w++) begin
				rrpv_new[w*RRPV_W +: RRPV_W] = rr_way[w] + lift;
			end
			rrpv_new[victim*RRPV_W +: RRPV_W] = depth;
		end
		sig_new = sig_rd_q;
		sig_new[victim*SIG_BITS +: SIG_BITS] = sig_q;

		psel_d = psel_q;
		if (state_q == ST_LOOK && !hit_q) begin
			priority if (srrip_leader) begin
				if (psel_q != '0) psel_d = psel_q - 1'b1;
			end else if (brrip_leader) begin
				if (psel_q != PSEL_MAX) psel_d = psel_q + 1'b1;
			end else begin
				psel_d = psel_q;
			end
		end
	end

	// memory port control
	always_comb begin
		set_re     = (state_q == ST_READ);
		rrpv_we    = clr_sets || (state_q == ST_LOOK);
		sig_we     = clr_sets || (state_q == ST_LOOK && !hit_q);
		set_waddr  = (state_q == ST_CLEAR) ? clr_q[SET_W-1:0] : set_q;
		rrpv_wdata = (state_q == ST_CLEAR) ? {RRPV_WORD_W{1'b1}} : rrpv_new;
		sig_wdata  = (state_q == ST_CLEAR) ? '0 : sig_new;

		rc_re    = (state_q == ST_READ) || (state_q == ST_LOOK && !hit_q);
		rc_raddr = (state_q == ST_READ) ? sig_q : old_sig;
		rc_we    = clr_sigs || (state_q == ST_LOOK && hit_q) || (state_q == ST_DEC);
		priority if (state_q == ST_CLEAR) begin
			rc_waddr = clr_q[SIG_BITS-1:0];
			rc_wdata = RC_RESET;
		end else if (state_q == ST_DEC) begin
			rc_waddr = old_sig_q;
			rc_wdata = (rc_rd_q == '0) ? rc_rd_q : rc_rd_q - 1'b1;
		end else begin
			rc_waddr = sig_q;
			rc_wdata = (rc_rd_q == RC_MAX) ? rc_rd_q : rc_rd_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (rrpv_we) begin
			rrpv_mem[set_waddr] <= rrpv_wdata;
		end
		if (set_re) begin
			rrpv_rd_q <= rrpv_mem[set_q];
		end
	end

	always_ff @(posedge clk) begin
		if (sig_we) begin
			sig_mem[set_waddr] <= sig_wdata;
		end
		if (set_re) begin
			sig_rd_q <= sig_mem[set_q];
		end
	end

	always_ff @(posedge clk) begin
		if (rc_we) begin
			rc_mem[rc_waddr] <= rc_wdata;
		end
		if (rc_re) begin
			rc_rd_q <= rc_mem[rc_raddr];
		end
	end

	`SDR_ASSERT_IMPL(a_psel_moves_on_miss, psel_q != $past(psel_q), $past(state_q) == ST_LOOK && !$past(hit_q))
	`SDR_ASSERT_IMPL(a_rrpv_write_owner, rrpv_we, state_q == ST_LOOK || state_q == ST_CLEAR)
	`SDR_ASSERT_IMPL(a_dec_follows_miss, state_q == ST_DEC, $past(state_q) == ST_LOOK && !hit_q)
	`SDR_ASSERT_NEXT(a_emit_loads_rsp, state_q == ST_EMIT && rsp_free, rsp_valid_q && state_q == ST_IDLE)

endmodule
